FILE: hdl/multi_channel_phase_sequencer_assert.svh
// Assertion macros for the phase sequencer. Both expect clk and arst_n in scope.
`ifndef MULTI_CHANNEL_PHASE_SEQUENCER_ASSERT_SVH
`define MULTI_CHANNEL_PHASE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define MCPS_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mcps assertion failed");

// next-cycle implication
`define MCPS_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mcps assertion failed");

`endif

FILE: hdl/mcps_pkg.sv
`default_nettype none

package mcps_pkg;

	localparam int MAX_PATTERNS_DEF = 8;
	localparam int MAX_PHASES_DEF   = 16;
	localparam int MAX_SLOTS_DEF    = 8;

	// selector field ranges
	localparam int SEL_PAT_N = 8;
	localparam int SEL_PH_N  = 16;
	localparam int SEL_SL_N  = 8;

	localparam logic [1:0] OP_LOAD_ACTION = 2'd0;
	localparam logic [1:0] OP_LOAD_SIZES  = 2'd1;
	localparam logic [1:0] OP_START_STOP  = 2'd2;
	localparam logic [1:0] OP_TICK        = 2'd3;

	localparam logic [1:0] KIND_LOCAL  = 2'd0;
	localparam logic [1:0] KIND_REMOTE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam int         CFG_AW       = 3;
	localparam logic [2:0] REG_TPS_ADDR = 3'd0;
	localparam logic [7:0] TPS_RESET    = 8'd10;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  pattern_sel;
		logic [3:0]  phase_sel;
		logic [2:0]  slot_sel;
		logic [15:0] duration_s;
		logic [23:0] colour_in;
		logic [7:0]  target_index;
		logic [4:0]  phase_total;
		logic [3:0]  slot_total;
		logic        run;
	} request_t;

	typedef struct packed {
		logic [1:0]  command_kind;
		logic [7:0]  node_out;
		logic [23:0] colour_out;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] duration;
		logic [23:0] colour;
		logic [7:0]  target;
	} action_t;

endpackage

`default_nettype wire

FILE: hdl/multi_channel_phase_sequencer.sv
// channel   direction  handshake                       payload
// request   in         start high while busy low        mcps_pkg::request_t
// result    out        strobe, one cycle, no backpress  mcps_pkg::result_t
// config    in         APB write, pready tied high      ticks_per_second at 0x0
//
// Loads never raise busy. Start/stop: the clear leaves in the cycle after accept; a stop
// then sends two more results, from ST_STOP1 and ST_STOP2 in turn. A start, and a tick,
// visit the active slots in turn: a slot that only counts down passes through ST_RD alone;
// a slot that reads the action table (one write port, registered read port) passes
// through ST_RD and ST_DAT and goes through the shared duration multiplier.
// Reset is asynchronous; the action and size tables have no reset and no clearing pass.
// Results cannot be stalled; at most one leaves per cycle.
`default_nettype none
`include "multi_channel_phase_sequencer_assert.svh"

module multi_channel_phase_sequencer #(
	parameter int MAX_PATTERNS = mcps_pkg::MAX_PATTERNS_DEF,
	parameter int MAX_PHASES   = mcps_pkg::MAX_PHASES_DEF,
	parameter int MAX_SLOTS    = mcps_pkg::MAX_SLOTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire mcps_pkg::request_t      request,
	output logic                         strobe,
	output mcps_pkg::result_t            result,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [mcps_pkg::CFG_AW-1:0]   paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import mcps_pkg::*;

	localparam int PI_W   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int PHI_W  = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int SLI_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int PC_W   = $clog2(MAX_PHASES + 1);
	localparam int SC_W   = $clog2(MAX_SLOTS + 1);
	localparam int ADDR_W = PI_W + PHI_W + SLI_W;
	localparam int DEPTH  = 1 << ADDR_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_DAT   = 3'd2;
	localparam logic [2:0] ST_STOP1 = 3'd3;
	localparam logic [2:0] ST_STOP2 = 3'd4;

	logic [2:0]        state_q;
	logic              tick_q;
	logic [SLI_W-1:0]  k_q;
	logic [MAX_SLOTS-1:0] exp_q;
	logic              running_q;
	logic [PI_W-1:0]   active_pattern_q;
	logic [SC_W-1:0]   active_slots_q;
	logic [PC_W-1:0]   active_phases_q;
	logic [7:0]        tps_q;
	logic              strobe_q;
	result_t           result_q;

	logic [23:0]       rem_q    [MAX_SLOTS];
	logic [PC_W-1:0]   phase_q  [MAX_SLOTS];
	logic [23:0]       colour_q [MAX_SLOTS];
	logic [7:0]        target_q [MAX_SLOTS];

	logic [PC_W-1:0]   size_phases_q [MAX_PATTERNS];
	logic [SC_W-1:0]   size_slots_q  [MAX_PATTERNS];

	action_t           tab [DEPTH];
	action_t           rd_data_q;

	logic [PI_W-1:0]   pat_tab [SEL_PAT_N];
	logic [PHI_W-1:0]  ph_tab  [SEL_PH_N];
	logic [SLI_W-1:0]  sl_tab  [SEL_SL_N];

	for (genvar gi = 0; gi < SEL_PAT_N; gi++) begin : g_pat
		assign pat_tab[gi] = PI_W'(gi % MAX_PATTERNS);
	end
	for (genvar gi = 0; gi < SEL_PH_N; gi++) begin : g_ph
		assign ph_tab[gi] = PHI_W'(gi % MAX_PHASES);
	end
	for (genvar gi = 0; gi < SEL_SL_N; gi++) begin : g_sl
		assign sl_tab[gi] = SLI_W'(gi % MAX_SLOTS);
	end

	logic              accept;
	logic [PI_W-1:0]   pat_w;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [PHI_W-1:0]  rd_idx;
	logic [PC_W-1:0]   cur_phase;
	logic [PC_W:0]     phase_inc;
	logic [23:0]       prod;
	logic [23:0]       new_ticks;
	logic              k_last;
	logic              later_exp;
	logic              last_now;
	logic [7:0]        fill_tgt;
	logic [MAX_SLOTS-1:0] exp_mask;
	logic              cfg_we;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign strobe  = strobe_q;
	assign result  = result_q;
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && (paddr == REG_TPS_ADDR);
	assign prdata  = (paddr == REG_TPS_ADDR) ? {24'd0, tps_q} : 32'd0;

	always_comb begin
		pat_w     = pat_tab[request.pattern_sel];
		wr_addr   = {pat_w, ph_tab[request.phase_sel], sl_tab[request.slot_sel]};
		cur_phase = phase_q[k_q];
		if (!tick_q || cur_phase >= active_phases_q)
			rd_idx = '0;
		else
			rd_idx = PHI_W'(cur_phase);
		rd_addr   = {active_pattern_q, rd_idx, k_q};
		phase_inc = (PC_W+1)'(cur_phase) + (PC_W+1)'(1);
		prod      = 24'(rd_data_q.duration * tps_q);
		new_ticks = (prod == 24'd0) ? 24'd1 : prod;
		k_last    = (SC_W'(k_q) + SC_W'(1)) == active_slots_q;
		later_exp = 1'b0;
		for (int j = 0; j < MAX_SLOTS; j++) begin
			if (exp_q[j] && (SLI_W'(j) > k_q))
				later_exp = 1'b1;
		end
		last_now  = tick_q ? !later_exp : k_last;
		fill_tgt  = tick_q ? target_q[k_q] : rd_data_q.target;
		for (int j = 0; j < MAX_SLOTS; j++) begin
			exp_mask[j] = (SC_W'(j) < active_slots_q) && (rem_q[j][23:1] == 23'd0);
		end
	end

	// action table, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (accept && request.operation == OP_LOAD_ACTION)
			tab[wr_addr] <= '{duration: request.duration_s,
				colour: request.colour_in,
				target: request.target_index - 8'd1};
		rd_data_q <= tab[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && request.operation == OP_LOAD_SIZES) begin
			size_phases_q[pat_w] <= (int'(request.phase_total) > MAX_PHASES) ?
				PC_W'(MAX_PHASES) : PC_W'(request.phase_total);
			size_slots_q[pat_w] <= (int'(request.slot_total) > MAX_SLOTS) ?
				SC_W'(MAX_SLOTS) : SC_W'(request.slot_total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			tick_q           <= 1'b0;
			k_q              <= '0;
			exp_q            <= '0;
			running_q        <= 1'b0;
			active_pattern_q <= '0;
			active_slots_q   <= '0;
			active_phases_q  <= '0;
			tps_q            <= TPS_RESET;
			strobe_q         <= 1'b0;
			result_q         <= '0;
			for (int j = 0; j < MAX_SLOTS; j++) begin
				rem_q[j]    <= '0;
				phase_q[j]  <= '0;
				colour_q[j] <= '0;
				target_q[j] <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we)
				tps_q <= pwdata[7:0];
			unique case (state_q)
				ST_IDLE: begin
					if (accept && request.operation == OP_START_STOP) begin
						active_pattern_q <= pat_w;
						active_slots_q   <= size_slots_q[pat_w];
						active_phases_q  <= size_phases_q[pat_w];
						running_q        <= request.run;
						tick_q           <= 1'b0;
						k_q              <= '0;
						strobe_q         <= 1'b1;
						result_q         <= '{command_kind: KIND_CLEAR, node_out: 8'd0,
							colour_out: 24'd0,
							last: request.run && (size_slots_q[pat_w] == '0)};
						if (!request.run)
							state_q <= ST_STOP1;
						else if (size_slots_q[pat_w] != '0)
							state_q <= ST_RD;
					end else if (accept && request.operation == OP_TICK) begin
						if (running_q && active_slots_q != '0) begin
							exp_q   <= exp_mask;
							tick_q  <= 1'b1;
							k_q     <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (!tick_q || exp_q[k_q]) begin
						state_q <= ST_DAT;
					end else begin
						rem_q[k_q] <= rem_q[k_q] - 24'd1;
						if (k_last)
							state_q <= ST_IDLE;
						else
							k_q <= k_q + SLI_W'(1);
					end
				end
				ST_DAT: begin
					rem_q[k_q]    <= new_ticks;
					colour_q[k_q] <= rd_data_q.colour;
					if (tick_q) begin
						phase_q[k_q] <= (phase_inc >= (PC_W+1)'(active_phases_q)) ?
							'0 : PC_W'(phase_inc);
					end else begin
						phase_q[k_q]  <= PC_W'(1);
						target_q[k_q] <= rd_data_q.target;
					end
					strobe_q <= 1'b1;
					result_q <= '{command_kind: (fill_tgt == 8'd0) ? KIND_LOCAL : KIND_REMOTE,
						node_out: fill_tgt, colour_out: rd_data_q.colour, last: last_now};
					if (k_last) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + SLI_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_STOP1: begin
					strobe_q <= 1'b1;
					result_q <= '{command_kind: KIND_LOCAL, node_out: 8'd0,
						colour_out: 24'd0, last: 1'b0};
					state_q  <= ST_STOP2;
				end
				ST_STOP2: begin
					strobe_q <= 1'b1;
					result_q <= '{command_kind: KIND_CLEAR, node_out: 8'd0,
						colour_out: 24'd0, last: 1'b1};
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MCPS_ASSERT_IMP(a_last_ends_item, strobe_q && result_q.last, state_q == ST_IDLE || (tick_q && state_q == ST_RD))
	`MCPS_ASSERT_IMP(a_clear_black, strobe_q && result_q.command_kind == KIND_CLEAR, result_q.colour_out == 24'd0 && result_q.node_out == 8'd0)
	`MCPS_ASSERT_IMP(a_dat_after_rd, state_q == ST_DAT, $past(state_q) == ST_RD)
	`MCPS_ASSERT_NXT(a_stop_seq, state_q == ST_STOP1, state_q == ST_STOP2 && strobe_q && result_q.command_kind == KIND_LOCAL)

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

import mcps_pkg::*;

class fill_scoreboard;
	action_t     actions[MAX_PATTERNS_DEF][MAX_PHASES_DEF][MAX_SLOTS_DEF];
	bit          action_known[MAX_PATTERNS_DEF][MAX_PHASES_DEF][MAX_SLOTS_DEF];
	logic [4:0]  size_phases[MAX_PATTERNS_DEF];
	logic [3:0]  size_slots[MAX_PATTERNS_DEF];
	bit          size_known[MAX_PATTERNS_DEF];
	logic [23:0] remaining[MAX_SLOTS_DEF];
	logic [3:0]  slot_phase[MAX_SLOTS_DEF];
	logic [23:0] slot_colour[MAX_SLOTS_DEF];
	logic [7:0]  slot_target[MAX_SLOTS_DEF];
	bit          running;
	logic [2:0]  run_pattern;
	logic [3:0]  run_slots;
	logic [4:0]  run_phases;
	logic [7:0]  tps;
	result_t     pending[$];
	int          fail_count;

	function new();
		foreach (remaining[k]) begin
			remaining[k] = '0;
			slot_phase[k] = '0;
			slot_colour[k] = '0;
			slot_target[k] = '0;
		end
		running = 1'b0;
		run_pattern = '0;
		run_slots = '0;
		run_phases = '0;
		tps = TPS_RESET;
		fail_count = 0;
	endfunction

	function void flag(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function logic [23:0] reload_ticks(logic [15:0] seconds);
		logic [31:0] prod;
		prod = 32'(seconds) * 32'(tps);
		return (prod[23:0] == '0) ? 24'd1 : prod[23:0];
	endfunction

	function result_t command(logic [1:0] kind, logic [7:0] node, logic [23:0] colour);
		result_t r;
		r.command_kind = kind;
		r.node_out = node;
		r.colour_out = colour;
		r.last = 1'b0;
		return r;
	endfunction

	function result_t fill(logic [7:0] node, logic [23:0] colour);
		return command((node == '0) ? KIND_LOCAL : KIND_REMOTE, node, colour);
	endfunction

	// returns 0 only for a tick while stopped
	function bit note_request(request_t q);
		result_t    batch[$];
		result_t    r;
		action_t    a;
		logic [3:0] idx;
		logic [4:0] nxt;
		int         k;
		case (q.operation)
		OP_LOAD_ACTION: begin
			a.duration = q.duration_s;
			a.colour = q.colour_in;
			a.target = q.target_index - 8'd1;
			actions[q.pattern_sel][q.phase_sel][q.slot_sel] = a;
			action_known[q.pattern_sel][q.phase_sel][q.slot_sel] = 1'b1;
		end
		OP_LOAD_SIZES: begin
			size_phases[q.pattern_sel] = (q.phase_total > 5'(MAX_PHASES_DEF)) ?
				5'(MAX_PHASES_DEF) : q.phase_total;
			size_slots[q.pattern_sel] = (q.slot_total > 4'(MAX_SLOTS_DEF)) ?
				4'(MAX_SLOTS_DEF) : q.slot_total;
			size_known[q.pattern_sel] = 1'b1;
		end
		OP_START_STOP: begin
			batch.push_back(command(KIND_CLEAR, '0, '0));
			run_pattern = q.pattern_sel;
			run_slots = size_slots[q.pattern_sel];
			run_phases = size_phases[q.pattern_sel];
			running = q.run;
			if (running) begin
				for (k = 0; k < run_slots; k++) begin
					a = actions[run_pattern][0][k];
					slot_colour[k] = a.colour;
					remaining[k] = reload_ticks(a.duration);
					slot_target[k] = a.target;
					slot_phase[k] = 4'd1;
					batch.push_back(fill(slot_target[k], slot_colour[k]));
				end
			end else begin
				batch.push_back(command(KIND_LOCAL, '0, '0));
				batch.push_back(command(KIND_CLEAR, '0, '0));
			end
		end
		default: begin
			if (!running) begin
				return 1'b0;
			end
			for (k = 0; k < run_slots; k++) begin
				if (remaining[k] > 24'd1) begin
					remaining[k] = remaining[k] - 24'd1;
				end else begin
					idx = slot_phase[k];
					if ({1'b0, idx} >= run_phases) begin
						idx = '0;
					end
					a = actions[run_pattern][idx][k];
					remaining[k] = reload_ticks(a.duration);
					slot_colour[k] = a.colour;
					batch.push_back(fill(slot_target[k], slot_colour[k]));
					nxt = {1'b0, slot_phase[k]} + 5'd1;
					slot_phase[k] = (nxt >= run_phases) ? 4'd0 : nxt[3:0];
				end
			end
		end
		endcase
		if (batch.size() > 0) begin
			r = batch.pop_back();
			r.last = 1'b1;
			batch.push_back(r);
		end
		foreach (batch[i]) begin
			pending.push_back(batch[i]);
		end
		return 1'b1;
	endfunction

	function void check_command(result_t got);
		result_t want;
		if (pending.size() == 0) begin
			flag($sformatf("unexpected command: kind %0d node %0d colour %h last %0b",
				got.command_kind, got.node_out, got.colour_out, got.last));
			return;
		end
		want = pending.pop_front();
		if (got.command_kind !== want.command_kind || got.node_out !== want.node_out ||
				got.colour_out !== want.colour_out || got.last !== want.last) begin
			flag($sformatf({"command mismatch: expected kind %0d node %0d colour %h last %0b,",
				" got kind %0d node %0d colour %h last %0b"},
				want.command_kind, want.node_out, want.colour_out, want.last,
				got.command_kind, got.node_out, got.colour_out, got.last));
		end
	endfunction
endclass

module testbench;
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	request_t          request = '0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic              busy;
	logic              strobe;
	result_t           result;
	logic [31:0]       prdata;
	logic              pready;

	fill_scoreboard sb = new();
	int idle_pct = 0;
	int items_done = 0;

	multi_channel_phase_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_command(result);
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic request_t random_request(logic [1:0] op);
		logic [95:0] raw;
		request_t    q;
		raw = {$urandom(), $urandom(), $urandom()};
		q = raw[$bits(request_t)-1:0];
		q.operation = op;
		return q;
	endfunction

	task automatic send(request_t q);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= q;
		do begin
			@(posedge clk);
		end while (busy);
		if (sb.note_request(q)) begin
			items_done++;
		end
	endtask

	task automatic put_action(logic [2:0] p, logic [3:0] ph, logic [2:0] sl,
			logic [15:0] dur, logic [23:0] colour, logic [7:0] tgt);
		request_t q;
		q = random_request(OP_LOAD_ACTION);
		q.pattern_sel = p;
		q.phase_sel = ph;
		q.slot_sel = sl;
		q.duration_s = dur;
		q.colour_in = colour;
		q.target_index = tgt;
		send(q);
	endtask

	task automatic random_action(logic [2:0] p, logic [3:0] ph, logic [2:0] sl);
		int          pick;
		logic [15:0] dur;
		logic [7:0]  tgt;
		pick = $urandom_range(99);
		if (pick < 70) begin
			dur = 16'($urandom_range(2));
		end else if (pick < 90) begin
			dur = 16'($urandom_range(20));
		end else begin
			dur = 16'($urandom());
		end
		pick = $urandom_range(99);
		if (pick < 30) begin
			tgt = 8'd1;
		end else if (pick < 35) begin
			tgt = 8'd0;
		end else begin
			tgt = 8'($urandom());
		end
		put_action(p, ph, sl, dur, 24'($urandom()), tgt);
	endtask

	task automatic put_sizes(logic [2:0] p, logic [4:0] phases, logic [3:0] slots);
		request_t q;
		q = random_request(OP_LOAD_SIZES);
		q.pattern_sel = p;
		q.phase_total = phases;
		q.slot_total = slots;
		send(q);
	endtask

	task automatic control(logic [2:0] p, logic run);
		request_t q;
		q = random_request(OP_START_STOP);
		q.pattern_sel = p;
		q.run = run;
		send(q);
	endtask

	task automatic tick();
		send(random_request(OP_TICK));
	endtask

	task automatic run_sequence();
		int r;
		int p;
		int ph_tot;
		int sl_tot;
		int n_ph;
		int n_sl;
		r = $urandom_range(99);
		if (r < 10) begin
			case ($urandom_range(2))
			0: send(random_request(OP_LOAD_ACTION));
			1: send(random_request(OP_LOAD_SIZES));
			default: tick();
			endcase
		end else if (r < 18) begin
			p = $urandom_range(7);
			if (!sb.size_known[p]) begin
				put_sizes(3'(p), 5'($urandom_range(4)), 4'($urandom_range(8)));
			end
			control(3'(p), 1'b0);
			repeat ($urandom_range(3)) tick();
		end else begin
			p = $urandom_range(7);
			ph_tot = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(31, 5);
			n_ph = (ph_tot == 0) ? 1 : ((ph_tot > MAX_PHASES_DEF) ? MAX_PHASES_DEF : ph_tot);
			if (n_ph > 4) begin
				sl_tot = $urandom_range(2, 1);
			end else begin
				sl_tot = ($urandom_range(99) < 90) ? $urandom_range(8) : $urandom_range(15, 9);
			end
			n_sl = (sl_tot > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : sl_tot;
			put_sizes(3'(p), 5'(ph_tot), 4'(sl_tot));
			for (int ph = 0; ph < n_ph; ph++) begin
				for (int sl = 0; sl < n_sl; sl++) begin
					if (!sb.action_known[p][ph][sl]) begin
						random_action(3'(p), 4'(ph), 3'(sl));
					end
				end
			end
			if (n_sl > 0) begin
				repeat ($urandom_range(2)) begin
					random_action(3'(p), 4'($urandom_range(n_ph - 1)),
						3'($urandom_range(n_sl - 1)));
				end
			end
			control(3'(p), 1'b1);
			repeat ($urandom_range(15)) tick();
			if ($urandom_range(99) < 35) begin
				control(3'(p), 1'b0);
			end
		end
	endtask

	// loads and idle ticks leave no command behind, so allow for a full slot walk
	task automatic drain();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 4000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_rate(logic [7:0] rate);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_TPS_ADDR;
		pwdata <= {24'd0, rate};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		sb.tps = rate;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== {24'd0, rate}) begin
			sb.flag($sformatf("rate register reads %h, expected %h", got, rate));
		end
	endtask

	initial begin
		logic [7:0] rates[4];
		int         idles[4];
		int         goal;
		rates = '{8'd255, 8'd0, 8'd1, 8'd0};
		rates[3] = 8'($urandom_range(254, 2));
		idles = '{0, 88, 0, 37};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating sizes, then a stop on that pattern
		put_sizes(3'd7, 5'd31, 4'd15);
		control(3'd7, 1'b0);
		put_sizes(3'd0, 5'd2, 4'd2);
		put_action(3'd0, 4'd0, 3'd0, 16'd0, 24'hFFFFFF, 8'd1);
		put_action(3'd0, 4'd0, 3'd1, 16'd1, 24'h000000, 8'd0);
		put_action(3'd0, 4'd1, 3'd0, 16'hFFFF, 24'hA5C3E1, 8'hFF);
		put_action(3'd0, 4'd1, 3'd1, 16'd0, 24'h123456, 8'd2);
		control(3'd0, 1'b1);
		repeat (3) tick();
		control(3'd0, 1'b0);
		tick();
		// empty pattern
		put_sizes(3'd1, 5'd0, 4'd0);
		control(3'd1, 1'b1);
		tick();
		// phase index runs past a single-phase count
		put_sizes(3'd2, 5'd1, 4'd1);
		put_action(3'd2, 4'd0, 3'd0, 16'd0, 24'h00FF00, 8'd1);
		control(3'd2, 1'b1);
		repeat (2) tick();
		put_sizes(3'd3, 5'd0, 4'd1);
		put_action(3'd3, 4'd0, 3'd0, 16'd3, 24'h0000FF, 8'd0);
		control(3'd3, 1'b1);
		tick();
		put_action(3'd6, 4'd15, 3'd7, 16'hFFFF, 24'hFFFFFF, 8'hFF);

		for (int n = 0; n < 4; n++) begin
			drain();
			write_rate(rates[n]);
			idle_pct = idles[n];
			goal = items_done + 115;
			while (items_done < goal) begin
				run_sequence();
			end
		end

		drain();
		if (sb.pending.size() != 0) begin
			sb.flag($sformatf("%0d commands never arrived", sb.pending.size()));
		end
		if (sb.fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

FILE: multi_channel_phase_sequencer.f
+incdir+hdl
hdl/mcps_pkg.sv
hdl/multi_channel_phase_sequencer.sv
verif/testbench.sv
